### sv/framed_command_receiver_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the framed command receiver
// Shorthand for clocked implication checks, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef FRAMED_COMMAND_RECEIVER_ASSERT_SVH
`define FRAMED_COMMAND_RECEIVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCR_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/fcr_pkg.sv
// ---------------------------------------------------------------------------
// Framed command receiver package
// Frame byte codes, operation codes and the command result record.
// ---------------------------------------------------------------------------
package fcr_pkg;

  // Frame delimiters and function codes.
  localparam logic [7:0] HEAD_BYTE   = 8'h8E;
  localparam logic [7:0] TAIL_BYTE   = 8'h8F;
  localparam logic [7:0] FUNC_STATUS = 8'h1F;
  localparam logic [7:0] FUNC_ACK    = 8'h2F;

  // Reset value of the station number.
  localparam logic [7:0] DEVICE_NUMBER_RESET = 8'h01;

  // Payload positions of the three kept bytes; the count saturates at FULL.
  localparam logic [1:0] POS_DEVICE   = 2'd0;
  localparam logic [1:0] POS_FUNCTION = 2'd1;
  localparam logic [1:0] POS_PARAM    = 2'd2;
  localparam logic [1:0] POS_FULL     = 2'd3;

  // Beat numbers of the outgoing request frame.
  localparam logic [1:0] BEAT_HEAD   = 2'd0;
  localparam logic [1:0] BEAT_DEVICE = 2'd1;
  localparam logic [1:0] BEAT_FUNC   = 2'd2;
  localparam logic [1:0] BEAT_TAIL   = 2'd3;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_ORDER = 2'd2,
    OP_RESET = 2'd3
  } op_t;

  // What one item leaves behind, as seen by the output stage.
  typedef struct packed {
    logic       send;
    logic       updated;
    logic [7:0] status;
    logic       acknowledged;
  } result_t;

endpackage

### sv/fcr_command_core.sv
// ---------------------------------------------------------------------------
// Framed command receiver core
// Frame parser and command state; one item is applied per step.
// ---------------------------------------------------------------------------
module fcr_command_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [1:0]          op,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          device_number,
  output fcr_pkg::result_t    result
);

  logic       in_frame;
  logic       in_frame_next;
  logic [1:0] payload_count;
  logic [1:0] payload_count_next;
  logic [7:0] frame_device;
  logic [7:0] frame_device_next;
  logic [7:0] frame_function;
  logic [7:0] frame_function_next;
  logic [7:0] frame_parameter;
  logic [7:0] frame_parameter_next;
  logic [7:0] status_reg;
  logic [7:0] status_reg_next;
  logic       acknowledged;
  logic       acknowledged_next;
  logic       order_pending;
  logic       order_pending_next;
  logic       updated;
  logic       send;

  // Next state for the item at the input register.
  always_comb begin
    in_frame_next        = in_frame;
    payload_count_next   = payload_count;
    frame_device_next    = frame_device;
    frame_function_next  = frame_function;
    frame_parameter_next = frame_parameter;
    status_reg_next      = status_reg;
    acknowledged_next    = acknowledged;
    order_pending_next   = order_pending;
    updated              = 1'b0;
    send                 = 1'b0;
    unique case (fcr_pkg::op_t'(op))
      fcr_pkg::OP_BYTE: begin
        if (!in_frame) begin
          // Outside a frame only the head byte matters.
          if (rx_byte == fcr_pkg::HEAD_BYTE) begin
            in_frame_next      = 1'b1;
            payload_count_next = fcr_pkg::POS_DEVICE;
          end
        end else if (rx_byte == fcr_pkg::TAIL_BYTE) begin
          // Tail: act on a complete frame addressed to this station.
          in_frame_next = 1'b0;
          if (payload_count == fcr_pkg::POS_FULL && frame_device == device_number) begin
            if (frame_function == fcr_pkg::FUNC_STATUS) begin
              status_reg_next = frame_parameter;
              updated         = 1'b1;
            end else if (frame_function == fcr_pkg::FUNC_ACK) begin
              acknowledged_next = 1'b1;
              updated           = 1'b1;
            end
          end
        end else begin
          // Payload byte: keep the first three, then saturate.
          case (payload_count)
            fcr_pkg::POS_DEVICE:   frame_device_next    = rx_byte;
            fcr_pkg::POS_FUNCTION: frame_function_next  = rx_byte;
            fcr_pkg::POS_PARAM:    frame_parameter_next = rx_byte;
            default: ;
          endcase
          if (payload_count != fcr_pkg::POS_FULL) begin
            payload_count_next = payload_count + 2'd1;
          end
        end
      end
      fcr_pkg::OP_TICK: begin
        send = order_pending && !acknowledged;
      end
      fcr_pkg::OP_ORDER: begin
        order_pending_next = 1'b1;
        acknowledged_next  = 1'b0;
        updated            = 1'b1;
      end
      fcr_pkg::OP_RESET: begin
        acknowledged_next = 1'b0;
        updated           = 1'b1;
      end
    endcase
  end

  // State registers advance only when the item moves to the output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame        <= 1'b0;
      payload_count   <= fcr_pkg::POS_DEVICE;
      frame_device    <= 8'h00;
      frame_function  <= 8'h00;
      frame_parameter <= 8'h00;
      status_reg      <= 8'h00;
      acknowledged    <= 1'b0;
      order_pending   <= 1'b0;
    end else if (step) begin
      in_frame        <= in_frame_next;
      payload_count   <= payload_count_next;
      frame_device    <= frame_device_next;
      frame_function  <= frame_function_next;
      frame_parameter <= frame_parameter_next;
      status_reg      <= status_reg_next;
      acknowledged    <= acknowledged_next;
      order_pending   <= order_pending_next;
    end
  end

  assign result.send         = send;
  assign result.updated      = updated;
  assign result.status       = status_reg_next;
  assign result.acknowledged = acknowledged_next;

endmodule

### sv/framed_command_receiver.sv
// ---------------------------------------------------------------------------
// Framed command receiver
// Byte-framed command parser with a station register and request sender.
// ---------------------------------------------------------------------------
// Each input item passes an input register, is applied to the frame and
// command state, and lands in the output register; a new item can be taken
// every cycle unless the output stalls. A timer tick that sends the request
// frame occupies the output register for four beats; the input register
// holds the next item during the first three of them. The station register
// is written through the configuration channel, which is always ready, and
// must be written only while the block is idle.
module framed_command_receiver (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       tx_last,
  output logic [7:0] device_status,
  output logic       request_done,
  output logic       updated
);

  `include "framed_command_receiver_assert.svh"

  logic             [7:0] device_number;
  logic                   s1_valid;
  logic             [1:0] s1_op;
  logic             [7:0] s1_byte;
  logic                   s1_advance;
  logic                   out_free;
  logic                   burst;
  logic             [1:0] beat;
  logic             [7:0] tx_device;
  fcr_pkg::result_t       result;

  // Station register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_number <= fcr_pkg::DEVICE_NUMBER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      device_number <= cfg_data;
    end
  end

  // Handshake between the input register and the output register.
  assign tx_last    = !burst || beat == fcr_pkg::BEAT_TAIL;
  assign out_free   = !out_valid || (out_ready && tx_last);
  assign s1_advance = s1_valid && out_free;
  assign in_ready   = !s1_valid || s1_advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op   <= op;
      s1_byte <= rx_byte;
    end
  end

  fcr_command_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (s1_advance),
    .op            (s1_op),
    .rx_byte       (s1_byte),
    .device_number (device_number),
    .result        (result)
  );

  // Output register control: one beat per plain item, four for a request.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      burst     <= 1'b0;
      beat      <= fcr_pkg::BEAT_HEAD;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
      burst     <= result.send;
      beat      <= fcr_pkg::BEAT_HEAD;
    end else if (out_valid && out_ready) begin
      if (tx_last) begin
        out_valid <= 1'b0;
      end else begin
        beat <= beat + 2'd1;
      end
    end
  end

  // Output payload, captured with the item.
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      tx_device     <= device_number;
      device_status <= result.status;
      request_done  <= result.acknowledged;
      updated       <= result.updated;
    end
  end

  // Request frame byte for the current beat.
  always_comb begin
    tx_byte = 8'h00;
    if (burst) begin
      case (beat)
        fcr_pkg::BEAT_HEAD:   tx_byte = fcr_pkg::HEAD_BYTE;
        fcr_pkg::BEAT_DEVICE: tx_byte = tx_device;
        fcr_pkg::BEAT_FUNC:   tx_byte = fcr_pkg::FUNC_ACK;
        default:              tx_byte = fcr_pkg::TAIL_BYTE;
      endcase
    end
  end

  assign tx_valid = burst;

  // A request frame keeps going until its tail beat is taken.
  `FCR_ASSERT_NEXT(a_burst_continues, out_valid && burst && out_ready && !tx_last, out_valid && burst, "request frame cut short")
  // A waiting item does not pass while a request frame is mid-flight.
  `FCR_ASSERT_SAME(a_input_held, s1_valid && out_valid && !tx_last, !in_ready, "input taken during request frame")
  // The last beat of a request frame carries the tail byte.
  `FCR_ASSERT_SAME(a_tail_last, out_valid && burst && tx_last, tx_byte == fcr_pkg::TAIL_BYTE, "request frame ends without tail")

endmodule

### test/tb.sv
// ---------------------------------------------------------------------------
// Testbench for the framed command receiver
// Drives framed byte streams, ticks, new orders and reset requests through
// the input channel. Every output item is checked against a behavioral
// predictor of the frame parser, status register and request sender.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 7;
  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_HOLD    = 80;
  localparam int PHASE_ITEMS  = 65;
  localparam int N_PHASES     = 5;
  localparam int N_DIRECTED   = 25;
  localparam int TAIL_CYCLES  = 8;

  // One output item as seen on the result port.
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic [7:0] status;
    logic       done;
    logic       upd;
  } response_t;

  // One row of the directed script; want is used only when typed is set.
  typedef struct packed {
    fcr_pkg::op_t op;
    logic [7:0]   data;
    logic         typed;
    response_t    want;
  } step_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_data = 8'h00;
  logic         in_valid = 1'b0;
  logic         in_ready;
  fcr_pkg::op_t op = fcr_pkg::OP_BYTE;
  logic [7:0]   rx_byte = 8'h00;
  logic         out_valid;
  logic         out_ready = 1'b1;
  logic         tx_valid;
  logic [7:0]   tx_byte;
  logic         tx_last;
  logic [7:0]   device_status;
  logic         request_done;
  logic         updated;

  // Side information that travels with the item currently offered.
  logic      item_typed = 1'b0;
  response_t item_want = '0;

  // Control between the stimulus and the output sink.
  logic gaps_on = 1'b1;
  logic hold_request = 1'b0;

  // Predictor copy of the configuration and the receiver state.
  logic [7:0] station_no = fcr_pkg::DEVICE_NUMBER_RESET;
  logic       rx_in_frame = 1'b0;
  logic [1:0] rx_count = 2'd0;
  logic [7:0] rx_device = 8'h00;
  logic [7:0] rx_function = 8'h00;
  logic [7:0] rx_param = 8'h00;
  logic [7:0] status_now = 8'h00;
  logic       ack_now = 1'b0;
  logic       order_open = 1'b0;

  response_t pending_responses[$];

  int mismatches = 0;
  int items_offered = 0;
  int results_seen = 0;
  int station_writes = 0;
  int request_frames = 0;
  int frames_acted = 0;

  step_t directed_steps [N_DIRECTED];

  framed_command_receiver dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .tx_valid     (tx_valid),
    .tx_byte      (tx_byte),
    .tx_last      (tx_last),
    .device_status(device_status),
    .request_done (request_done),
    .updated      (updated)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // A single-beat response that sends nothing.
  function automatic response_t quiet_resp(logic [7:0] st, logic ack, logic upd);
    return '{tx_valid: 1'b0, tx_byte: 8'h00, tx_last: 1'b1, status: st, done: ack,
             upd: upd};
  endfunction

  // Appends one expected response at the back of the queue.
  function automatic void queue_response(response_t r);
    pending_responses.insert(pending_responses.size(), r);
  endfunction

  // Feeds one received byte to the frame parser; returns 1 when a command was applied.
  function automatic logic take_frame_byte(logic [7:0] b);
    logic hit;
    hit = 1'b0;
    if (!rx_in_frame) begin
      if (b == fcr_pkg::HEAD_BYTE) begin
        rx_in_frame = 1'b1;
        rx_count = fcr_pkg::POS_DEVICE;
      end
    end else if (b == fcr_pkg::TAIL_BYTE) begin
      // Only a frame with all three payload bytes for this station counts.
      rx_in_frame = 1'b0;
      if (rx_count == fcr_pkg::POS_FULL && rx_device == station_no) begin
        if (rx_function == fcr_pkg::FUNC_STATUS) begin
          status_now = rx_param;
          hit = 1'b1;
        end else if (rx_function == fcr_pkg::FUNC_ACK) begin
          ack_now = 1'b1;
          hit = 1'b1;
        end
      end
    end else begin
      case (rx_count)
        fcr_pkg::POS_DEVICE:   rx_device = b;
        fcr_pkg::POS_FUNCTION: rx_function = b;
        fcr_pkg::POS_PARAM:    rx_param = b;
        default:               ;
      endcase
      if (rx_count != fcr_pkg::POS_FULL) rx_count = rx_count + 2'd1;
    end
    if (hit) frames_acted++;
    return hit;
  endfunction

  // Works out the responses to one accepted item and queues them.
  function automatic void predict_response(fcr_pkg::op_t o, logic [7:0] b);
    response_t  r;
    logic       upd;
    logic [7:0] frame_bytes [4];
    upd = 1'b0;
    if (o == fcr_pkg::OP_TICK && order_open && !ack_now) begin
      // A pending, unacknowledged order sends the four-byte request frame.
      request_frames++;
      frame_bytes = '{fcr_pkg::HEAD_BYTE, station_no, fcr_pkg::FUNC_ACK, fcr_pkg::TAIL_BYTE};
      for (int beat = 0; beat < 4; beat++) begin
        r = '{tx_valid: 1'b1, tx_byte: frame_bytes[beat], tx_last: (beat == 3),
              status: status_now, done: ack_now, upd: 1'b0};
        queue_response(r);
      end
    end else begin
      case (o)
        fcr_pkg::OP_BYTE: upd = take_frame_byte(b);
        fcr_pkg::OP_ORDER: begin
          order_open = 1'b1;
          ack_now = 1'b0;
          upd = 1'b1;
        end
        fcr_pkg::OP_RESET: begin
          ack_now = 1'b0;
          upd = 1'b1;
        end
        default: upd = 1'b0;
      endcase
      queue_response(quiet_resp(status_now, ack_now, upd));
    end
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] exp);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, exp);
    mismatches++;
  endtask

  // Output check first, then configuration and input acceptance for the predictor.
  always @(posedge clk) begin
    response_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_responses.size() == 0) begin
          report_mismatch("item with nothing expected, tx_byte", tx_byte, 8'h00);
        end else begin
          want = pending_responses.pop_front();
          if (tx_valid !== want.tx_valid)
            report_mismatch("tx_valid", 8'(tx_valid), 8'(want.tx_valid));
          if (tx_byte !== want.tx_byte)
            report_mismatch("tx_byte", tx_byte, want.tx_byte);
          if (tx_last !== want.tx_last)
            report_mismatch("tx_last", 8'(tx_last), 8'(want.tx_last));
          if (device_status !== want.status)
            report_mismatch("device_status", device_status, want.status);
          if (request_done !== want.done)
            report_mismatch("request_done", 8'(request_done), 8'(want.done));
          if (updated !== want.upd)
            report_mismatch("updated", 8'(updated), 8'(want.upd));
        end
      end
      if (cfg_valid && cfg_ready) begin
        station_no = cfg_data;
        station_writes++;
      end
      if (in_valid && in_ready) begin
        predict_response(op, rx_byte);
        // Typed rows of the directed script replace the predicted response.
        if (item_typed) pending_responses[$] = item_want;
      end
    end
  end

  // Output sink: random stall bursts, plus one long hold-off on request.
  initial begin
    int burst;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
        out_ready = 1'b1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 15);
        out_ready = 1'b0;
        repeat (burst) @(negedge clk);
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any handshake.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Watchdog expired after %0d cycles without a handshake.", IDLE_LIMIT);
    $display("** framed_command_receiver: FAILED **");
    $finish;
  end

  // Offers one item, with an optional idle burst in front, and waits for acceptance.
  task automatic drive_item(fcr_pkg::op_t o, logic [7:0] b, logic typed, response_t want);
    int gap;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    op = o;
    rx_byte = b;
    item_typed = typed;
    item_want = want;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    items_offered++;
  endtask

  task automatic offer_item(fcr_pkg::op_t o, logic [7:0] b);
    drive_item(o, b, 1'b0, '0);
  endtask

  // Stops offering and waits until every expected item has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  task automatic write_station(logic [7:0] value);
    @(negedge clk);
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One random stretch: mostly whole frames, otherwise events and stray bytes.
  task automatic send_random_sequence();
    int         pick;
    int         len;
    logic [7:0] dev;
    logic [7:0] func;
    logic [7:0] extra;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      dev = ($urandom_range(0, 3) != 0) ? station_no : 8'($urandom_range(0, 255));
      case ($urandom_range(0, 4))
        0, 1:    func = fcr_pkg::FUNC_STATUS;
        2, 3:    func = fcr_pkg::FUNC_ACK;
        default: func = 8'($urandom_range(0, 255));
      endcase
      // Mostly three payload bytes; now and then a short or a padded frame.
      len = ($urandom_range(0, 4) != 0) ? 3 : $urandom_range(0, 6);
      offer_item(fcr_pkg::OP_BYTE, fcr_pkg::HEAD_BYTE);
      if (len > 0) offer_item(fcr_pkg::OP_BYTE, dev);
      if (len > 1) offer_item(fcr_pkg::OP_BYTE, func);
      if (len > 2) offer_item(fcr_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
      for (int k = 3; k < len; k++) begin
        extra = 8'($urandom_range(0, 255));
        if (extra == fcr_pkg::TAIL_BYTE) extra = fcr_pkg::HEAD_BYTE;
        offer_item(fcr_pkg::OP_BYTE, extra);
      end
      // Once in a while the frame is left open and the next head lands inside it.
      if ($urandom_range(0, 15) != 0) offer_item(fcr_pkg::OP_BYTE, fcr_pkg::TAIL_BYTE);
    end else if (pick < 72) begin
      offer_item(fcr_pkg::OP_TICK, 8'($urandom_range(0, 255)));
    end else if (pick < 82) begin
      offer_item(fcr_pkg::OP_ORDER, 8'($urandom_range(0, 255)));
    end else if (pick < 88) begin
      offer_item(fcr_pkg::OP_RESET, 8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 3))
        0:       offer_item(fcr_pkg::OP_BYTE, fcr_pkg::HEAD_BYTE);
        1:       offer_item(fcr_pkg::OP_BYTE, fcr_pkg::TAIL_BYTE);
        default: offer_item(fcr_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Main sequence: reset, directed script, then random phases per station setting.
  initial begin
    int         target;
    int         half;
    logic       paused;
    logic [7:0] station_pick;
    paused = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // Directed script at the reset station number 1.
    directed_steps = '{
      '{fcr_pkg::OP_TICK,  8'h00, 1'b1, quiet_resp(8'h00, 1'b0, 1'b0)}, // tick, no order
      '{fcr_pkg::OP_BYTE,  fcr_pkg::TAIL_BYTE, 1'b1,
        quiet_resp(8'h00, 1'b0, 1'b0)},                                 // tail outside frame
      '{fcr_pkg::OP_ORDER, 8'hFF, 1'b1, quiet_resp(8'h00, 1'b0, 1'b1)}, // new order
      '{fcr_pkg::OP_TICK,  8'h55, 1'b0, '0},                            // sends request
      '{fcr_pkg::OP_BYTE,  fcr_pkg::HEAD_BYTE, 1'b0, '0},               // status frame
      '{fcr_pkg::OP_BYTE,  8'h01, 1'b0, '0},
      '{fcr_pkg::OP_BYTE,  fcr_pkg::FUNC_STATUS, 1'b0, '0},
      '{fcr_pkg::OP_BYTE,  8'hFF, 1'b0, '0},
      '{fcr_pkg::OP_BYTE,  fcr_pkg::TAIL_BYTE, 1'b1, quiet_resp(8'hFF, 1'b0, 1'b1)},
      '{fcr_pkg::OP_BYTE,  fcr_pkg::HEAD_BYTE, 1'b0, '0},               // head inside frame
      '{fcr_pkg::OP_BYTE,  fcr_pkg::HEAD_BYTE, 1'b0, '0},
      '{fcr_pkg::OP_BYTE,  fcr_pkg::FUNC_ACK, 1'b0, '0},
      '{fcr_pkg::OP_BYTE,  8'h00, 1'b0, '0},
      '{fcr_pkg::OP_BYTE,  fcr_pkg::TAIL_BYTE, 1'b1,
        quiet_resp(8'hFF, 1'b0, 1'b0)},                                 // wrong device
      '{fcr_pkg::OP_BYTE,  fcr_pkg::HEAD_BYTE, 1'b0, '0},               // short frame
      '{fcr_pkg::OP_BYTE,  8'h01, 1'b0, '0},
      '{fcr_pkg::OP_BYTE,  fcr_pkg::TAIL_BYTE, 1'b1, quiet_resp(8'hFF, 1'b0, 1'b0)},
      '{fcr_pkg::OP_BYTE,  fcr_pkg::HEAD_BYTE, 1'b0, '0},               // long ack frame
      '{fcr_pkg::OP_BYTE,  8'h01, 1'b0, '0},
      '{fcr_pkg::OP_BYTE,  fcr_pkg::FUNC_ACK, 1'b0, '0},
      '{fcr_pkg::OP_BYTE,  8'h00, 1'b0, '0},
      '{fcr_pkg::OP_BYTE,  8'hAA, 1'b0, '0},
      '{fcr_pkg::OP_BYTE,  fcr_pkg::TAIL_BYTE, 1'b1, quiet_resp(8'hFF, 1'b1, 1'b1)},
      '{fcr_pkg::OP_TICK,  8'h00, 1'b1, quiet_resp(8'hFF, 1'b1, 1'b0)}, // already acknowledged
      '{fcr_pkg::OP_RESET, 8'hFF, 1'b1, quiet_resp(8'hFF, 1'b0, 1'b1)}  // reset request
    };
    for (int i = 0; i < N_DIRECTED; i++)
      drive_item(directed_steps[i].op, directed_steps[i].data, directed_steps[i].typed,
                 directed_steps[i].want);

    // Random phases, each at its own station number.
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      case (p)
        0:       station_pick = 8'h00;
        1:       station_pick = 8'hFF;
        2:       station_pick = fcr_pkg::HEAD_BYTE;
        default: station_pick = 8'($urandom_range(0, 255));
      endcase
      write_station(station_pick);
      gaps_on = (p != N_PHASES - 1);
      if (p == 1) hold_request = 1'b1;
      target = items_offered + PHASE_ITEMS;
      half = items_offered + PHASE_ITEMS / 2;
      while (items_offered < target) begin
        // Midway through one phase the sender waits for the output to run dry.
        if (p == 2 && !paused && items_offered >= half) begin
          wait_drained();
          paused = 1'b1;
        end
        send_random_sequence();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d items and %0d results over %0d station writes: %0d request frames,",
             items_offered, results_seen, station_writes, request_frames);
    $display("%0d frames acted on, a long output hold-off, a drained pause and a gap-free phase.",
             frames_acted);
    if (mismatches == 0 && pending_responses.size() == 0) begin
      $display("** framed_command_receiver: PASSED **");
    end else begin
      $display("%0d mismatches, %0d items still expected.", mismatches,
               pending_responses.size());
      $display("** framed_command_receiver: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/fcr_pkg.sv
sv/fcr_command_core.sv
sv/framed_command_receiver.sv
test/tb.sv
